### rtl/jtkf_pkg.sv
// jtkf_pkg: shared types and constants for the top-level JSON key finder.
// Used by json_top_level_key_finder and jtkf_checker; no dependencies.
package jtkf_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int KEY_LEN_W  = 6;
  localparam int OFFSET_W   = 15;
  localparam int STATUS_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_0 = 3'd1;

  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OBJ_END    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_COLON   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TEXT_END   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEPTH_OVFL = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_LEAD,
    MODE_SCAN,
    MODE_STR,
    MODE_ESC,
    MODE_KEY,
    MODE_KEYESC,
    MODE_COLON,
    MODE_VALUE
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic                key_found;
    logic [STATUS_W-1:0] scan_status;
    logic [OFFSET_W-1:0] value_offset;
  } out_word_t;

endpackage

### rtl/json_top_level_key_finder.sv
// json_top_level_key_finder: scans JSON text a byte per word for a top-level key.
// Depends on jtkf_pkg for the word types, mode enum, codes and characters.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_word_t  (text_byte, end_of_text)
//  out_     output     out_valid / out_stall  out_word_t (key_found, status, offset)
//  cfg_     input      cfg_write_en           cfg_index, cfg_data
//
// One input word per cycle while in_stall is low; the scan state updates in the accept
// cycle. An output register plus one skid entry part the two sides: a result goes to
// the skid entry if the output is held; in_stall rises only while that entry is full.
// Synchronous active-low reset clears scan state, key registers and output valids.
module json_top_level_key_finder
  import jtkf_pkg::*;
#(
  parameter int KEY_MAX_BYTES  = 32,
  parameter int TEXT_MAX_BYTES = 16384,
  parameter int DEPTH_MAX      = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W   = $clog2(TEXT_MAX_BYTES + 1);
  localparam int DEPTH_W = $clog2(DEPTH_MAX + 1);
  localparam int KIDX_W  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [7:0]            key_r [KEY_MAX_BYTES];

  mode_t                 mode_r, mode_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [KEY_LEN_W-1:0]  cand_len_r, cand_len_nxt;
  logic                  cand_match_r, cand_match_nxt;
  logic                  answer_r, answer_nxt;

  out_word_t             res;
  logic                  emit;
  logic                  do_scan, do_cmp;
  logic                  accept, take;
  logic [7:0]            c;
  logic                  last;
  logic [POS_W-1:0]      pos_inc;
  logic [7:0]            key_byte;

  logic                  out_valid_r, skid_valid_r;
  out_word_t             out_word_r, skid_word_r;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) || (ch == 8'h0D);
  endfunction

  function automatic out_word_t finish_res(input mode_t m, input logic [POS_W-1:0] off);
    out_word_t r;
    r = '0;
    if (m == MODE_COLON) begin
      r.scan_status = ST_NO_COLON;
    end else if (m == MODE_VALUE) begin
      r.key_found    = 1'b1;
      r.scan_status  = ST_FOUND;
      r.value_offset = OFFSET_W'(off);
    end else begin
      r.scan_status = ST_TEXT_END;
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
    end else if (cfg_write_en && cfg_index == REG_KEY_LENGTH) begin
      key_len_r <= cfg_data[KEY_LEN_W-1:0];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_reg
    for (genvar b = 0; b < 8; b++) begin : g_byte
      if (j * 8 + b < KEY_MAX_BYTES) begin : g_kb
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            key_r[j*8+b] <= '0;
          end else if (cfg_write_en && cfg_index == REG_KEY_BYTES_0 + CFG_IDX_W'(j)) begin
            key_r[j*8+b] <= cfg_data[b*8 +: 8];
          end
        end
      end
    end
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid_r && !out_stall;
  assign c        = in_word.text_byte;
  assign last     = in_word.end_of_text;
  assign pos_inc  = pos_r + POS_W'(1);
  assign key_byte = key_r[cand_len_r[KIDX_W-1:0]];

  // scan step
  always_comb begin
    mode_nxt       = mode_r;
    depth_nxt      = depth_r;
    cand_len_nxt   = cand_len_r;
    cand_match_nxt = cand_match_r;
    answer_nxt     = answer_r;
    pos_nxt        = pos_r;
    res            = '0;
    emit           = 1'b0;
    do_scan        = 1'b0;
    do_cmp         = 1'b0;

    if (!answer_r) begin
      if (c == CH_NUL || pos_r >= POS_W'(TEXT_MAX_BYTES)) begin
        res  = finish_res(mode_r, pos_r);
        emit = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_LEAD: begin
            if (!is_ws(c)) begin
              mode_nxt = MODE_SCAN;
              do_scan  = (c != CH_LBRACE);
            end
          end
          MODE_SCAN: do_scan = 1'b1;
          MODE_STR: begin
            if (c == CH_BSLASH) mode_nxt = MODE_ESC;
            else if (c == CH_QUOTE) mode_nxt = MODE_SCAN;
          end
          MODE_ESC: mode_nxt = MODE_STR;
          MODE_KEY: begin
            if (c == CH_QUOTE) begin
              mode_nxt = (cand_match_r && cand_len_r == key_len_r) ? MODE_COLON : MODE_SCAN;
            end else begin
              do_cmp = 1'b1;
              if (c == CH_BSLASH) mode_nxt = MODE_KEYESC;
            end
          end
          MODE_KEYESC: begin
            do_cmp   = 1'b1;
            mode_nxt = MODE_KEY;
          end
          MODE_COLON: begin
            if (c == CH_COLON) begin
              mode_nxt = MODE_VALUE;
            end else if (!is_ws(c)) begin
              res.scan_status = ST_NO_COLON;
              emit            = 1'b1;
            end
          end
          MODE_VALUE: begin
            if (!is_ws(c)) begin
              res.key_found    = 1'b1;
              res.scan_status  = ST_FOUND;
              res.value_offset = OFFSET_W'(pos_r);
              emit             = 1'b1;
            end
          end
        endcase

        if (do_scan) begin
          priority if (c == CH_QUOTE) begin
            if (depth_r == '0) begin
              mode_nxt       = MODE_KEY;
              cand_len_nxt   = '0;
              cand_match_nxt = 1'b1;
            end else begin
              mode_nxt = MODE_STR;
            end
          end else if (c == CH_LBRACE || c == CH_LBRACK) begin
            if (depth_r >= DEPTH_W'(DEPTH_MAX)) begin
              res.scan_status = ST_DEPTH_OVFL;
              emit            = 1'b1;
            end else begin
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            if (depth_r == '0) begin
              res.scan_status = ST_OBJ_END;
              emit            = 1'b1;
            end else begin
              depth_nxt = depth_r - DEPTH_W'(1);
            end
          end else begin
          end
        end

        if (do_cmp) begin
          if (cand_len_r >= key_len_r || cand_len_r >= KEY_LEN_W'(KEY_MAX_BYTES) ||
              key_byte != c) begin
            cand_match_nxt = 1'b0;
          end
          if (cand_len_r != '1) cand_len_nxt = cand_len_r + KEY_LEN_W'(1);
        end

        if (!emit && last) begin
          res  = finish_res(mode_nxt, pos_inc);
          emit = 1'b1;
        end
      end
    end

    if (emit) answer_nxt = 1'b1;
    if (pos_r < POS_W'(TEXT_MAX_BYTES)) pos_nxt = pos_inc;

    if (last) begin
      mode_nxt       = MODE_LEAD;
      depth_nxt      = '0;
      pos_nxt        = '0;
      cand_len_nxt   = '0;
      cand_match_nxt = 1'b1;
      answer_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_LEAD;
      depth_r      <= '0;
      pos_r        <= '0;
      cand_len_r   <= '0;
      cand_match_r <= 1'b1;
      answer_r     <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      depth_r      <= depth_nxt;
      pos_r        <= pos_nxt;
      cand_len_r   <= cand_len_nxt;
      cand_match_r <= cand_match_nxt;
      answer_r     <= answer_nxt;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      out_valid_r  <= skid_valid_r || (accept && emit);
      skid_valid_r <= 1'b0;
    end else if (accept && emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_word_r <= skid_valid_r ? skid_word_r : res;
    end else if (accept && emit) begin
      skid_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/jtkf_checker.sv
// jtkf_checker: port-level assertions for json_top_level_key_finder, plus its bind.
// Depends on jtkf_pkg for the word types and status codes.
module jtkf_checker
  import jtkf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("out_word changed while stalled");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.key_found == (out_word.scan_status == ST_FOUND)))
    else $error("key_found disagrees with scan_status");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.key_found |-> out_word.value_offset == '0)
    else $error("value_offset nonzero without a found key");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without a held result");

endmodule

bind json_top_level_key_finder jtkf_checker u_jtkf_checker (.*);
